@@ design/cdq_pkg.sv @@
`timescale 1ns / 1ps

package cdq_pkg;

  localparam int unsigned PORT_W = 32;
  localparam int unsigned OCC_W  = 5;

  typedef enum logic [1:0] {
    OP_PUSH_REAR  = 2'd0,
    OP_PUSH_FRONT = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_REAR   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SHOW
  } state_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_PUSH_REAR,
    ACT_PUSH_FRONT,
    ACT_POP_FRONT,
    ACT_POP_REAR
  } act_t;

  typedef struct packed {
    logic    load;
    logic    capture;
    act_t    act;
    status_t result;
  } ctl_cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    full;
    logic    empty;
  } dp_stat_t;

endpackage

@@ design/cdq_ctrl.sv @@
`timescale 1ns / 1ps

module cdq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  cdq_pkg::dp_stat_t stat,
  output cdq_pkg::ctl_cmd_t cmd,
  output logic              busy,
  output logic              done
);

  cdq_pkg::state_t state;
  cdq_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cdq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd.load    = 1'b0;
    cmd.capture = 1'b0;
    cmd.act     = cdq_pkg::ACT_NONE;
    cmd.result  = cdq_pkg::STAT_DONE;
    busy        = 1'b1;
    done        = 1'b0;
    case (state)
      cdq_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = cdq_pkg::ST_EXEC;
        end
      end
      cdq_pkg::ST_EXEC: begin
        cmd.capture = 1'b1;
        state_next  = cdq_pkg::ST_SHOW;
        case (stat.op)
          cdq_pkg::OP_PUSH_REAR, cdq_pkg::OP_PUSH_FRONT: begin
            if (stat.full) begin
              cmd.result = cdq_pkg::STAT_FULL;
            end else if (stat.op == cdq_pkg::OP_PUSH_REAR) begin
              cmd.act = cdq_pkg::ACT_PUSH_REAR;
            end else begin
              cmd.act = cdq_pkg::ACT_PUSH_FRONT;
            end
          end
          default: begin
            if (stat.empty) begin
              cmd.result = cdq_pkg::STAT_EMPTY;
            end else if (stat.op == cdq_pkg::OP_POP_FRONT) begin
              cmd.act = cdq_pkg::ACT_POP_FRONT;
            end else begin
              cmd.act = cdq_pkg::ACT_POP_REAR;
            end
          end
        endcase
      end
      cdq_pkg::ST_SHOW: begin
        done       = 1'b1;
        state_next = cdq_pkg::ST_IDLE;
      end
      default: begin
        state_next = cdq_pkg::ST_IDLE;
      end
    endcase
  end

  a_accept_to_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 done)
    else $error("item not answered two cycles after acceptance");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    stat.full |-> !(cmd.act == cdq_pkg::ACT_PUSH_REAR || cmd.act == cdq_pkg::ACT_PUSH_FRONT))
    else $error("push issued into a full ring");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    stat.empty |-> !(cmd.act == cdq_pkg::ACT_POP_FRONT || cmd.act == cdq_pkg::ACT_POP_REAR))
    else $error("pop issued from an empty ring");

endmodule

@@ design/cdq_datapath.sv @@
`timescale 1ns / 1ps

module cdq_datapath #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  cdq_pkg::ctl_cmd_t                   cmd,
  input  logic [1:0]                          opcode,
  input  logic signed [cdq_pkg::PORT_W-1:0]   data_in,
  output cdq_pkg::dp_stat_t                   stat,
  output logic signed [cdq_pkg::PORT_W-1:0]   data_out,
  output logic [1:0]                          status,
  output logic [cdq_pkg::OCC_W-1:0]           occupancy
);

  localparam int unsigned PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned WIDE_W = (DATA_WIDTH > cdq_pkg::PORT_W) ? DATA_WIDTH : cdq_pkg::PORT_W;
  localparam int unsigned EXT_W  = (CNT_W > cdq_pkg::OCC_W) ? CNT_W : cdq_pkg::OCC_W;
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  cdq_pkg::opcode_t      op;
  logic [DATA_WIDTH-1:0] word;
  logic [PTR_W-1:0]      head;
  logic [PTR_W-1:0]      tail;
  logic [CNT_W-1:0]      count;
  logic [DATA_WIDTH-1:0] rd_data;
  logic                  pop_ok;
  cdq_pkg::status_t      result;

  logic [WIDE_W-1:0]     wide_in;
  logic [WIDE_W-1:0]     rd_wide;
  logic [EXT_W-1:0]      cnt_ext;
  logic [PTR_W-1:0]      head_inc;
  logic [PTR_W-1:0]      head_dec;
  logic [PTR_W-1:0]      tail_inc;
  logic [PTR_W-1:0]      tail_dec;
  logic [PTR_W-1:0]      addr;
  logic                  empty;
  logic                  wr_en;
  logic                  is_pop;

  assign empty    = (count == '0);
  assign head_inc = (head == LAST) ? '0 : head + 1'b1;
  assign head_dec = (head == '0) ? LAST : head - 1'b1;
  assign tail_inc = (tail == LAST) ? '0 : tail + 1'b1;
  assign tail_dec = (tail == '0) ? LAST : tail - 1'b1;

  assign stat.op    = op;
  assign stat.full  = (count == CNT_W'(DEPTH));
  assign stat.empty = empty;

  assign wr_en  = (cmd.act == cdq_pkg::ACT_PUSH_REAR) || (cmd.act == cdq_pkg::ACT_PUSH_FRONT);
  assign is_pop = (cmd.act == cdq_pkg::ACT_POP_FRONT) || (cmd.act == cdq_pkg::ACT_POP_REAR);

  always_comb begin
    case (cmd.act)
      cdq_pkg::ACT_PUSH_REAR:  addr = empty ? '0 : tail_inc;
      cdq_pkg::ACT_PUSH_FRONT: addr = empty ? '0 : head_dec;
      cdq_pkg::ACT_POP_REAR:   addr = tail;
      default:                 addr = head;
    endcase
  end

  // sign-extend, then keep the stored width
  assign wide_in = WIDE_W'(data_in);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op   <= cdq_pkg::opcode_t'(opcode);
      word <= wide_in[DATA_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= word;
    end
    rd_data <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head   <= '0;
      tail   <= '0;
      count  <= '0;
      pop_ok <= 1'b0;
      result <= cdq_pkg::STAT_DONE;
    end else begin
      if (cmd.capture) begin
        pop_ok <= is_pop;
        result <= cmd.result;
      end
      case (cmd.act)
        cdq_pkg::ACT_PUSH_REAR: begin
          if (empty) begin
            head <= '0;
            tail <= '0;
          end else begin
            tail <= tail_inc;
          end
          count <= count + 1'b1;
        end
        cdq_pkg::ACT_PUSH_FRONT: begin
          if (empty) begin
            head <= '0;
            tail <= '0;
          end else begin
            head <= head_dec;
          end
          count <= count + 1'b1;
        end
        cdq_pkg::ACT_POP_FRONT: begin
          head  <= head_inc;
          count <= count - 1'b1;
        end
        cdq_pkg::ACT_POP_REAR: begin
          tail  <= tail_dec;
          count <= count - 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign rd_wide   = WIDE_W'(rd_data);
  assign data_out  = pop_ok ? signed'(rd_wide[cdq_pkg::PORT_W-1:0]) : '0;
  assign status    = result;
  assign cnt_ext   = EXT_W'(count);
  assign occupancy = cnt_ext[cdq_pkg::OCC_W-1:0];

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count beyond ring depth");

  a_pop_decrements: assert property (@(posedge clk) disable iff (rst)
    is_pop |=> (count + 1'b1) == $past(count))
    else $error("pop did not take one entry");

  a_push_increments: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> count == $past(count) + 1'b1)
    else $error("push did not add one entry");

endmodule

@@ design/circular_deque.sv @@
`timescale 1ns / 1ps
// result strobe (done) comes in the SHOW state, after the EXEC state, held one cycle
// a new item is taken only in the idle state, once the previous result has shown
// busy stays high from acceptance until the result cycle has ended
// the receiver cannot stall: each result shows for exactly one cycle
// reset (rst, synchronous): pointers, count and controller cleared, ring contents kept

module circular_deque #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [1:0]                        opcode,
  input  logic signed [cdq_pkg::PORT_W-1:0] data_in,
  output logic                              busy,
  output logic                              done,
  output logic signed [cdq_pkg::PORT_W-1:0] data_out,
  output logic [1:0]                        status,
  output logic [cdq_pkg::OCC_W-1:0]         occupancy
);

  cdq_pkg::ctl_cmd_t cmd;
  cdq_pkg::dp_stat_t stat;

  cdq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  cdq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .opcode    (opcode),
    .data_in   (data_in),
    .stat      (stat),
    .data_out  (data_out),
    .status    (status),
    .occupancy (occupancy)
  );

endmodule

@@ tb/deque_checker.sv @@
`timescale 1ns / 1ps

module deque_checker
  import cdq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic                     busy,
  input  logic [1:0]               opcode,
  input  logic signed [PORT_W-1:0] data_in,
  input  logic                     done,
  input  logic signed [PORT_W-1:0] data_out,
  input  logic [1:0]               status,
  input  logic [OCC_W-1:0]         occupancy,
  output int                       outstanding,
  output int                       fail_count
);

  typedef struct {
    logic signed [PORT_W-1:0] data_out;
    status_t                  status;
    logic [OCC_W-1:0]         occupancy;
  } outcome_t;

  logic [PORT_W-1:0] ring [DEPTH];
  int                front;
  int                rear;
  int                fill;
  outcome_t          predicted_outcomes [$];
  int                errors;

  initial begin
    front = 0;
    rear = 0;
    fill = 0;
    errors = 0;
    outstanding = 0;
    fail_count = 0;
  end

  function automatic int step_up(input int i);
    return (i == DEPTH - 1) ? 0 : i + 1;
  endfunction

  function automatic int step_down(input int i);
    return (i == 0) ? DEPTH - 1 : i - 1;
  endfunction

  task automatic deque_apply(input opcode_t op, input logic [PORT_W-1:0] word);
    outcome_t r;
    r.data_out = '0;
    r.status = STAT_DONE;
    case (op)
      OP_PUSH_REAR, OP_PUSH_FRONT: begin
        if (fill == DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          if (fill == 0) begin
            front = 0;
            rear = 0;
            ring[0] = word;
          end else if (op == OP_PUSH_REAR) begin
            rear = step_up(rear);
            ring[rear] = word;
          end else begin
            front = step_down(front);
            ring[front] = word;
          end
          fill++;
        end
      end
      default: begin
        if (fill == 0) begin
          r.status = STAT_EMPTY;
        end else if (op == OP_POP_FRONT) begin
          r.data_out = ring[front];
          front = step_up(front);
          fill--;
        end else begin
          r.data_out = ring[rear];
          rear = step_down(rear);
          fill--;
        end
      end
    endcase
    r.occupancy = fill[OCC_W-1:0];
    predicted_outcomes.push_back(r);
  endtask

  always @(posedge clk) begin : watch
    outcome_t want;
    if (rst) begin
      front = 0;
      rear = 0;
      fill = 0;
      predicted_outcomes.delete();
    end else begin
      if (done) begin
        if (predicted_outcomes.size() == 0) begin
          $error("result with no item outstanding");
          errors++;
        end else begin
          want = predicted_outcomes.pop_front();
          if (data_out !== want.data_out) begin
            $error("data_out: expected %0d, got %0d", want.data_out, data_out);
            errors++;
          end
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            errors++;
          end
          if (occupancy !== want.occupancy) begin
            $error("occupancy: expected %0d, got %0d", want.occupancy, occupancy);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        deque_apply(opcode_t'(opcode), data_in);
      end
    end
    outstanding <= predicted_outcomes.size();
    fail_count <= errors;
  end

endmodule

@@ tb/circular_deque_tb.sv @@
`timescale 1ns / 1ps

module circular_deque_tb;
  import cdq_pkg::*;

  localparam int ITEMS_PER_PHASE = 567;
  localparam int CYCLE_LIMIT     = 300000;

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic [1:0]               opcode = OP_PUSH_REAR;
  logic signed [PORT_W-1:0] data_in = '0;
  logic                     busy;
  logic                     done;
  logic signed [PORT_W-1:0] data_out;
  logic [1:0]               status;
  logic [OCC_W-1:0]         occupancy;
  int                       outstanding;
  int                       fail_count;
  int                       idle_pct = 0;
  int                       cycles = 0;

  circular_deque dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .opcode   (opcode),
    .data_in  (data_in),
    .busy     (busy),
    .done     (done),
    .data_out (data_out),
    .status   (status),
    .occupancy(occupancy)
  );

  deque_checker chk (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .opcode     (opcode),
    .data_in    (data_in),
    .done       (done),
    .data_out   (data_out),
    .status     (status),
    .occupancy  (occupancy),
    .outstanding(outstanding),
    .fail_count (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_op(input opcode_t op, input logic [PORT_W-1:0] word);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    opcode <= op;
    data_in <= word;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic opcode_t pick_op(input int push_pct);
    if ($urandom_range(0, 99) < push_pct)
      return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
    return $urandom_range(0, 1) ? OP_POP_REAR : OP_POP_FRONT;
  endfunction

  function automatic logic [PORT_W-1:0] pick_word();
    case ($urandom_range(0, 15))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int push_pct;
    push_pct = 50;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty pops, extreme words, pointer wrap at both ends
    send_op(OP_POP_FRONT, 32'h1234_5678);
    send_op(OP_POP_REAR, '1);
    send_op(OP_PUSH_REAR, 32'h7fff_ffff);
    send_op(OP_PUSH_FRONT, 32'h8000_0000);
    send_op(OP_PUSH_REAR, '0);
    send_op(OP_PUSH_FRONT, '1);
    send_op(OP_POP_FRONT, '0);
    send_op(OP_POP_REAR, '0);
    send_op(OP_POP_FRONT, '0);
    send_op(OP_POP_REAR, '0);
    send_op(OP_POP_REAR, '0);
    send_op(OP_PUSH_FRONT, 32'h5a5a_a5a5);
    send_op(OP_PUSH_FRONT, 32'ha5a5_5a5a);
    send_op(OP_PUSH_REAR, 32'h0f0f_f0f0);
    send_op(OP_POP_REAR, '0);
    send_op(OP_POP_FRONT, '0);
    send_op(OP_POP_FRONT, '0);
    send_op(OP_POP_FRONT, '0);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 25 : (ph == 1) ? 83 : 0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // bias towards filling or emptying so both full and empty get hit
        if (n % 40 == 0) begin
          case ($urandom_range(0, 3))
            0: push_pct = 90;
            1: push_pct = 10;
            2: push_pct = 55;
            default: push_pct = $urandom_range(0, 100);
          endcase
        end
        send_op(pick_op(push_pct), pick_word());
        if (ph == 2 && n == ITEMS_PER_PHASE / 2) drain();
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
